FILE: hdl/dbq_pkg.sv
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared types and constants for the multi-input debounce qualifier.
// ----------------------------------------------------------------------------
package dbq_pkg;

  localparam int unsigned NUM_CH      = 7;
  localparam int unsigned ASSERT_W    = 6;
  localparam int unsigned RELEASE_W   = 5;
  localparam int unsigned CFG_INDEX_W = 8;

  localparam int unsigned DEF_SAMPLE_DIVIDE    = 3;
  localparam int unsigned DEF_TICKS_PER_SECOND = 10;

  // Channel order: button, door, undervolt, meter, ignition, antenna, power cut
  localparam int unsigned CH_BUTTON    = 0;
  localparam int unsigned CH_DOOR      = 1;
  localparam int unsigned CH_UNDERVOLT = 2;
  localparam int unsigned CH_METER     = 3;
  localparam int unsigned CH_IGNITION  = 4;
  localparam int unsigned CH_ANTENNA   = 5;
  localparam int unsigned CH_POWER_CUT = 6;

  localparam int unsigned ASSERT_THR  [NUM_CH] = '{5, 6, 40, 15, 6, 18, 18};
  localparam int unsigned RELEASE_THR [NUM_CH] = '{2, 2, 3, 3, 2, 18, 18};

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DOOR_ACTIVE_HIGH       = 8'd0,
    CFG_METER_ACTIVE_LEVEL     = 8'd1,
    CFG_METER_ENABLE           = 8'd2,
    CFG_EXTENDED_INPUTS_ENABLE = 8'd3
  } cfg_index_t;

  typedef struct packed {
    logic sample;
    logic pulse;
  } dbq_timing_t;

  typedef struct packed {
    logic changed;
    logic active;
    logic level;
  } dbq_ch_status_t;

endpackage

FILE: hdl/dbq_timer.sv
// ----------------------------------------------------------------------------
// dbq_timer
// Tick phase counter: flags sample ticks and the one-second pulse.
// ----------------------------------------------------------------------------
module dbq_timer #(
  parameter int unsigned SAMPLE_DIVIDE    = dbq_pkg::DEF_SAMPLE_DIVIDE,
  parameter int unsigned TICKS_PER_SECOND = dbq_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  output dbq_pkg::dbq_timing_t timing
);
  import dbq_pkg::*;

  localparam int unsigned PHASE_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned SUB_W   = $clog2(SAMPLE_DIVIDE + 1);

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W-1:0] phase_next;
  logic [SUB_W-1:0]   sub;
  logic [SUB_W-1:0]   sub_inc;
  logic [SUB_W-1:0]   sub_next;

  // sub tracks phase modulo SAMPLE_DIVIDE; it restarts with the phase
  always_comb begin
    phase_inc     = phase + PHASE_W'(1);
    sub_inc       = sub + SUB_W'(1);
    timing.sample = (sub_inc == SUB_W'(SAMPLE_DIVIDE));
    timing.pulse  = (phase_inc >= PHASE_W'(TICKS_PER_SECOND));
    phase_next    = timing.pulse ? '0 : phase_inc;
    if (timing.pulse || timing.sample) begin
      sub_next = '0;
    end else begin
      sub_next = sub_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      sub   <= '0;
    end else if (step) begin
      phase <= phase_next;
      sub   <= sub_next;
    end
  end

endmodule

FILE: hdl/dbq_channel.sv
// ----------------------------------------------------------------------------
// dbq_channel
// One debounce channel: assert/release counters with asymmetric thresholds.
// ----------------------------------------------------------------------------
module dbq_channel #(
  parameter int unsigned ASSERT_LIMIT  = 5,
  parameter int unsigned RELEASE_LIMIT = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    sample_en,
  input  logic                    pin,
  input  logic                    active_level,
  output dbq_pkg::dbq_ch_status_t status
);
  import dbq_pkg::*;

  logic [ASSERT_W-1:0]  assert_count;
  logic [ASSERT_W-1:0]  assert_count_next;
  logic [ASSERT_W-1:0]  assert_inc;
  logic [RELEASE_W-1:0] release_count;
  logic [RELEASE_W-1:0] release_count_next;
  logic [RELEASE_W-1:0] release_inc;
  logic                 active;
  logic                 active_next;
  logic                 hit;

  always_comb begin
    assert_inc         = assert_count + ASSERT_W'(1);
    release_inc        = release_count + RELEASE_W'(1);
    hit                = (pin == active_level);
    assert_count_next  = assert_count;
    release_count_next = release_count;
    active_next        = active;
    status.changed     = 1'b0;
    if (sample_en) begin
      if (hit) begin
        release_count_next = '0;
        if (!active) begin
          if (assert_inc >= ASSERT_W'(ASSERT_LIMIT)) begin
            assert_count_next = '0;
            active_next       = 1'b1;
            status.changed    = 1'b1;
          end else begin
            assert_count_next = assert_inc;
          end
        end
      end else begin
        assert_count_next = '0;
        if (active) begin
          if (release_inc >= RELEASE_W'(RELEASE_LIMIT)) begin
            release_count_next = '0;
            active_next        = 1'b0;
            status.changed     = 1'b1;
          end else begin
            release_count_next = release_inc;
          end
        end
      end
    end
    status.active = active_next;
    status.level  = status.changed & pin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assert_count  <= '0;
      release_count <= '0;
      active        <= 1'b0;
    end else if (step) begin
      assert_count  <= assert_count_next;
      release_count <= release_count_next;
      active        <= active_next;
    end
  end

endmodule

FILE: hdl/multi_input_debounce_qualifier.sv
// ----------------------------------------------------------------------------
// multi_input_debounce_qualifier
// Seven-channel pin debouncer with asymmetric assert/release hysteresis.
//
//   channel  signals                                    direction
//   -------  -----------------------------------------  ---------
//   in       in_valid/in_ready, seven *_pin levels      input
//   out      out_valid/out_ready, sample_tick, masks,   output
//            second_pulse
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   input
//
// Each tick beat is latched in an input register, evaluated by one pass of
// shallow counter logic, and then lands in the result register; one beat
// per cycle is sustained while out_ready stays high.
// A stalled result register holds the input register; in_ready drops only
// when both are full. Reset (rst, synchronous) clears phase, counters, flags,
// valids and the config registers to their defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module multi_input_debounce_qualifier #(
  parameter int unsigned SAMPLE_DIVIDE    = dbq_pkg::DEF_SAMPLE_DIVIDE,
  parameter int unsigned TICKS_PER_SECOND = dbq_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic                            clk,
  input  logic                            rst,
  // tick input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            button_pin,
  input  logic                            door_pin,
  input  logic                            undervolt_pin,
  input  logic                            meter_pin,
  input  logic                            ignition_pin,
  input  logic                            antenna_pin,
  input  logic                            power_cut_pin,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            sample_tick,
  output logic [dbq_pkg::NUM_CH-1:0]      changed_mask,
  output logic [dbq_pkg::NUM_CH-1:0]      active_mask,
  output logic [dbq_pkg::NUM_CH-1:0]      level_mask,
  output logic                            second_pulse,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dbq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                            cfg_data
);
  import dbq_pkg::*;

  // configuration registers
  logic door_active_high;
  logic meter_active_level;
  logic meter_enable;
  logic extended_inputs_enable;

  // input register
  logic              pins_valid;
  logic [NUM_CH-1:0] pins;

  // pipeline control
  logic advance;
  logic step;

  logic [NUM_CH-1:0] act_lvl;
  logic [NUM_CH-1:0] ch_en;
  dbq_timing_t       timing;
  dbq_ch_status_t    ch_status [NUM_CH];
  logic [NUM_CH-1:0] changed_vec;
  logic [NUM_CH-1:0] active_vec;
  logic [NUM_CH-1:0] level_vec;

  assign cfg_ready = 1'b1;

  // The result register can take a beat when empty or being drained.
  assign advance  = !out_valid || out_ready;
  assign step     = pins_valid && advance;
  assign in_ready = !pins_valid || advance;

  // Write the addressed config bit; drop writes beyond the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      door_active_high       <= 1'b1;
      meter_active_level     <= 1'b0;
      meter_enable           <= 1'b1;
      extended_inputs_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DOOR_ACTIVE_HIGH:       door_active_high       <= cfg_data;
        CFG_METER_ACTIVE_LEVEL:     meter_active_level     <= cfg_data;
        CFG_METER_ENABLE:           meter_enable           <= cfg_data;
        CFG_EXTENDED_INPUTS_ENABLE: extended_inputs_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold while the result side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      pins_valid <= 1'b0;
    end else if (in_ready) begin
      pins_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pins[CH_BUTTON]    <= button_pin;
      pins[CH_DOOR]      <= door_pin;
      pins[CH_UNDERVOLT] <= undervolt_pin;
      pins[CH_METER]     <= meter_pin;
      pins[CH_IGNITION]  <= ignition_pin;
      pins[CH_ANTENNA]   <= antenna_pin;
      pins[CH_POWER_CUT] <= power_cut_pin;
    end
  end

  // Per-channel active level and enable; most pins are active low.
  always_comb begin
    act_lvl               = '0;
    act_lvl[CH_DOOR]      = door_active_high;
    act_lvl[CH_METER]     = meter_active_level;
    act_lvl[CH_ANTENNA]   = 1'b1;
    ch_en                 = '1;
    ch_en[CH_METER]       = meter_enable;
    ch_en[CH_ANTENNA]     = extended_inputs_enable;
    ch_en[CH_POWER_CUT]   = extended_inputs_enable;
  end

  dbq_timer #(
    .SAMPLE_DIVIDE    (SAMPLE_DIVIDE),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_timer (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .timing (timing)
  );

  // Disabled channels see no sample: counts and flag freeze, no change shown.
  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    dbq_channel #(
      .ASSERT_LIMIT  (ASSERT_THR[i]),
      .RELEASE_LIMIT (RELEASE_THR[i])
    ) u_channel (
      .clk          (clk),
      .rst          (rst),
      .step         (step),
      .sample_en    (timing.sample && ch_en[i]),
      .pin          (pins[i]),
      .active_level (act_lvl[i]),
      .status       (ch_status[i])
    );
    assign changed_vec[i] = ch_status[i].changed;
    assign active_vec[i]  = ch_status[i].active;
    assign level_vec[i]   = ch_status[i].level;
  end

  // Result register: advance when empty or taken, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pins_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sample_tick  <= timing.sample;
      changed_mask <= changed_vec;
      active_mask  <= active_vec;
      level_mask   <= level_vec;
      second_pulse <= timing.pulse;
    end
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seven-channel debounce qualifier. A queue of
// tick beats, mostly pin runs long enough to qualify or release channels
// with short glitches mixed in, drives the tick channel. A local qualifier
// predicts one status beat per tick, and every status beat is checked field
// by field against it under changing door, meter and extended-input settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dbq_pkg::*;

  localparam int unsigned SAMPLE_DIVIDE    = DEF_SAMPLE_DIVIDE;
  localparam int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LOW  = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HIGH = 8'd255;

  localparam int LONG_HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES     = 8;
  localparam int MAX_REPORTS      = 10;
  localparam int NUM_SETTINGS     = 8;

  // Register plan per phase: {extended enable, meter enable, meter level, door high}.
  localparam logic [3:0] REG_PLAN [NUM_SETTINGS] = '{
    4'b1101, 4'b1110, 4'b0010, 4'b0111, 4'b1001, 4'b1100, 4'b1111, 4'b0000
  };

  typedef struct packed {
    logic              sample;
    logic [NUM_CH-1:0] changed;
    logic [NUM_CH-1:0] active;
    logic [NUM_CH-1:0] level;
    logic              pulse;
  } tick_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid      = 1'b0;
  logic in_ready;
  logic button_pin    = 1'b0;
  logic door_pin      = 1'b0;
  logic undervolt_pin = 1'b0;
  logic meter_pin     = 1'b0;
  logic ignition_pin  = 1'b0;
  logic antenna_pin   = 1'b0;
  logic power_cut_pin = 1'b0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              sample_tick;
  logic [NUM_CH-1:0] changed_mask;
  logic [NUM_CH-1:0] active_mask;
  logic [NUM_CH-1:0] level_mask;
  logic              second_pulse;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_data  = 1'b0;

  // Tick beats waiting to be driven, and status beats waiting to come back.
  logic [NUM_CH-1:0] pending_ticks [$];
  tick_status_t      status_due    [$];

  // Local qualifier state and register copies.
  logic [3:0]           sec_phase;
  logic [ASSERT_W-1:0]  hold_up_cnt [NUM_CH];
  logic [RELEASE_W-1:0] let_go_cnt  [NUM_CH];
  logic [NUM_CH-1:0]    qual_flags;
  logic                 door_high_r;
  logic                 meter_lvl_r;
  logic                 meter_en_r;
  logic                 ext_en_r;

  // Pin run generator.
  logic [NUM_CH-1:0] run_level = '0;
  int                run_left [NUM_CH];

  int  ticks_queued   = 0;
  int  results_seen   = 0;
  int  mismatches     = 0;
  int  reg_writes     = 0;
  int  samples_seen   = 0;
  int  seconds_seen   = 0;
  int  rises          = 0;
  int  falls          = 0;
  logic [NUM_CH-1:0] channels_moved = '0;

  bit  in_fire        = 1'b0;
  bit  idle_enable    = 1'b1;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  hold_left      = 0;
  int  holds_asked    = 0;
  int  holds_served   = 0;

  multi_input_debounce_qualifier #(
    .SAMPLE_DIVIDE    (SAMPLE_DIVIDE),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_pin    (button_pin),
    .door_pin      (door_pin),
    .undervolt_pin (undervolt_pin),
    .meter_pin     (meter_pin),
    .ignition_pin  (ignition_pin),
    .antenna_pin   (antenna_pin),
    .power_cut_pin (power_cut_pin),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_tick   (sample_tick),
    .changed_mask  (changed_mask),
    .active_mask   (active_mask),
    .level_mask    (level_mask),
    .second_pulse  (second_pulse),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run one tick through the local qualifier and queue the status it implies.
  task automatic qualify_tick(input logic [NUM_CH-1:0] pins);
    tick_status_t      st;
    logic [NUM_CH-1:0] act_lvl;
    logic [NUM_CH-1:0] en;
    st = '0;
    // Active levels: button, undervolt, ignition and power cut are active low.
    act_lvl              = '0;
    act_lvl[CH_DOOR]     = door_high_r;
    act_lvl[CH_METER]    = meter_lvl_r;
    act_lvl[CH_ANTENNA]  = 1'b1;
    en                   = '1;
    en[CH_METER]         = meter_en_r;
    en[CH_ANTENNA]       = ext_en_r;
    en[CH_POWER_CUT]     = ext_en_r;

    sec_phase = sec_phase + 4'd1;
    // Test the sample slot on the phase before it wraps, so a sample and a
    // second can land on the same tick.
    if ((sec_phase % SAMPLE_DIVIDE) == 0) begin
      st.sample = 1'b1;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (en[ch]) begin
          if (pins[ch] == act_lvl[ch]) begin
            let_go_cnt[ch] = '0;
            if (!qual_flags[ch]) begin
              hold_up_cnt[ch] = hold_up_cnt[ch] + 1'b1;
              if (hold_up_cnt[ch] >= ASSERT_THR[ch]) begin
                qual_flags[ch]  = 1'b1;
                hold_up_cnt[ch] = '0;
                st.changed[ch]  = 1'b1;
                st.level[ch]    = pins[ch];
                rises++;
              end
            end
          end else begin
            hold_up_cnt[ch] = '0;
            if (qual_flags[ch]) begin
              let_go_cnt[ch] = let_go_cnt[ch] + 1'b1;
              if (let_go_cnt[ch] >= RELEASE_THR[ch]) begin
                qual_flags[ch] = 1'b0;
                let_go_cnt[ch] = '0;
                st.changed[ch] = 1'b1;
                st.level[ch]   = pins[ch];
                falls++;
              end
            end
          end
        end
      end
      samples_seen++;
    end
    if (sec_phase >= TICKS_PER_SECOND) begin
      sec_phase = '0;
      st.pulse  = 1'b1;
      seconds_seen++;
    end
    st.active = qual_flags;
    channels_moved |= st.changed;
    status_due.push_back(st);
  endtask

  // Track accepted tick and register beats; keep the local qualifier in step.
  always @(posedge clk) begin
    if (rst) begin
      in_fire     = 1'b0;
      sec_phase   = '0;
      qual_flags  = '0;
      door_high_r = 1'b1;
      meter_lvl_r = 1'b0;
      meter_en_r  = 1'b1;
      ext_en_r    = 1'b1;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        hold_up_cnt[ch] = '0;
        let_go_cnt[ch]  = '0;
      end
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        qualify_tick({power_cut_pin, antenna_pin, ignition_pin, meter_pin,
                      undervolt_pin, door_pin, button_pin});
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_DOOR_ACTIVE_HIGH:       door_high_r = cfg_data;
          CFG_METER_ACTIVE_LEVEL:     meter_lvl_r = cfg_data;
          CFG_METER_ENABLE:           meter_en_r  = cfg_data;
          CFG_EXTENDED_INPUTS_ENABLE: ext_en_r    = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Tick driver: advance to the next queued beat once the current one is taken,
  // with random gaps between beats while idling is enabled.
  always @(negedge clk) begin
    logic [NUM_CH-1:0] pins;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_ticks.size() > 0) begin
        pins = pending_ticks.pop_front();
        button_pin    <= pins[CH_BUTTON];
        door_pin      <= pins[CH_DOOR];
        undervolt_pin <= pins[CH_UNDERVOLT];
        meter_pin     <= pins[CH_METER];
        ignition_pin  <= pins[CH_IGNITION];
        antenna_pin   <= pins[CH_ANTENNA];
        power_cut_pin <= pins[CH_POWER_CUT];
        in_valid      <= 1'b1;
        if (idle_enable && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 18);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Status receiver: a requested long hold-off first, then random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: status beat %0d, %s expected 0x%0h got 0x%0h",
                 $realtime, results_seen, name, want, got);
      end
    end
  endtask

  // Status monitor: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    tick_status_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: status beat %0d arrived with no tick waiting",
                   $realtime, results_seen);
        end
      end else begin
        want = status_due.pop_front();
        check_field("sample_tick",  want.sample,  sample_tick);
        check_field("changed_mask", want.changed, changed_mask);
        check_field("active_mask",  want.active,  active_mask);
        check_field("level_mask",   want.level,   level_mask);
        check_field("second_pulse", want.pulse,   second_pulse);
      end
    end
  end

  function automatic void queue_tick(input logic [NUM_CH-1:0] pins);
    pending_ticks.push_back(pins);
    ticks_queued++;
  endfunction

  // Hold each pin at a level for a run: short runs act as bounce, long runs
  // let the slow channels qualify. Add single-tick glitches on top.
  function automatic void queue_pin_runs(input int count);
    logic [NUM_CH-1:0] pins;
    for (int n = 0; n < count; n++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (run_left[ch] == 0) begin
          run_level[ch] = $urandom_range(0, 1);
          case ($urandom_range(0, 3))
            0:       run_left[ch] = $urandom_range(1, 4);
            1:       run_left[ch] = $urandom_range(5, 30);
            default: run_left[ch] = $urandom_range(30, 150);
          endcase
        end
        run_left[ch]--;
      end
      pins = run_level;
      if ($urandom_range(0, 15) == 0) begin
        pins[$urandom_range(0, NUM_CH - 1)] ^= 1'b1;
      end
      queue_tick(pins);
    end
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_regs(input logic [3:0] plan);
    write_reg(CFG_DOOR_ACTIVE_HIGH,       plan[0]);
    write_reg(CFG_METER_ACTIVE_LEVEL,     plan[1]);
    write_reg(CFG_METER_ENABLE,           plan[2]);
    write_reg(CFG_EXTENDED_INPUTS_ENABLE, plan[3]);
  endtask

  // Every tick yields one status beat, so drained means all queued came back.
  task automatic wait_drained();
    @(negedge clk);
    while (results_seen < ticks_queued) @(negedge clk);
  endtask

  initial begin
    for (int ch = 0; ch < NUM_CH; ch++) run_left[ch] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unmapped indexes: data 0 would clear door polarity or the extended
    // enable if the decode aliased low bits.
    write_reg(CFG_UNMAPPED_LOW, 1'b0);
    write_reg(CFG_UNMAPPED_HIGH, 1'b0);

    // Directed: all-low, all-high, alternating and walking patterns.
    queue_tick('0);
    queue_tick('1);
    queue_tick(7'h55);
    queue_tick(7'h2A);
    for (int ch = 0; ch < NUM_CH; ch++) queue_tick(7'(1 << ch));
    for (int ch = 0; ch < NUM_CH; ch++) queue_tick(~7'(1 << ch));
    repeat (3) queue_tick('0);
    repeat (3) queue_tick('1);
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      apply_regs(REG_PLAN[p]);
      // Keep one calm phase and the final phase free of idling.
      idle_enable = (p != 4) && (p != NUM_SETTINGS - 1);
      if (p == 2) begin
        // Stall the receiver long enough to back the block up to its input.
        queue_pin_runs(100);
        holds_asked++;
      end else if (p == 5) begin
        // Pause the sender until every status beat is back, then resume.
        queue_pin_runs(50);
        wait_drained();
        queue_pin_runs(50);
      end else begin
        queue_pin_runs(100);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (status_due.size() != 0) begin
      mismatches += status_due.size();
      $display("%0d predicted status beats never arrived", status_due.size());
    end

    $display("Covered %0d ticks, %0d sample ticks and %0d seconds over %0d register writes",
             ticks_queued, samples_seen, seconds_seen, reg_writes);
    $display("Qualified transitions: %0d to active, %0d to idle, channels moved %b",
             rises, falls, channels_moved);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: %0d of %0d status beats received", results_seen, ticks_queued);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
hdl/dbq_pkg.sv
hdl/dbq_timer.sv
hdl/dbq_channel.sv
hdl/multi_input_debounce_qualifier.sv
bench/testbench.sv
